>>> src/sst_pkg.sv
// shared types and codes for the small set table
package sst_pkg;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int OUT_POSW = 6;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

endpackage

>>> src/small_set_table.sv
// set of distinct values in arrival order with sequential search and shift
// a read by index passes through the registered memory read; a bad index answers at once;
//   lookup and insert scan from entry 0 up to the count; a delete hit shifts the later entries down
// a new request is taken only while busy is low
// result is shown for one cycle with o_valid; the receiver cannot stall
// synchronous active-low reset empties the set; entries need no clearing
module small_set_table #(
    parameter int CAPACITY = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_mode,
    input  logic signed [31:0]          i_value,
    input  logic [4:0]                  i_index,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic                        o_found,
    output logic [5:0]                  o_position,
    output logic [5:0]                  o_count,
    output logic signed [31:0]          o_read_value
);

    // pointer/count width holds CAPACITY itself, address width indexes the memory
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);
    localparam int IW = (CW > sst_pkg::INDEX_W) ? CW : sst_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,      // issue read of entry at pointer, or end of scan
        S_CMP,        // compare fetched entry with the request value
        S_SHIFT_RD,   // read the next entry during a delete
        S_SHIFT_WR,   // write it one place down
        S_READ_RD,    // read by index
        S_READ_OUT
    } t_state;

    t_state               r_state;
    sst_pkg::t_mode       r_mode;
    logic [31:0]          r_value;
    logic [CW-1:0]        r_ptr;
    logic [CW-1:0]        r_count;

    // registered result beat
    logic                 r_valid;
    sst_pkg::t_status     r_status;
    logic                 r_found;
    logic [CW-1:0]        r_pos;
    logic [CW-1:0]        r_out_count;
    logic [31:0]          r_read_value;

    // entry memory, one write and one registered read a cycle
    logic [31:0]          r_mem [CAPACITY];
    logic [31:0]          r_rd_data;

    logic [CW:0]          ptr_inc;
    logic [PW-1:0]        mem_rd_addr;
    logic                 mem_we;
    logic [PW-1:0]        mem_wr_addr;
    logic [31:0]          mem_wr_data;
    logic                 hit;
    logic                 set_full;
    logic                 scan_end;
    logic [IW-1:0]        idx_ext;
    logic [IW-1:0]        cnt_ext;

    assign ptr_inc  = {1'b0, r_ptr} + 1'b1;
    assign hit      = (r_rd_data == r_value);
    assign set_full = (r_count == CW'(CAPACITY));
    assign scan_end = (r_ptr == r_count);
    assign idx_ext  = IW'(i_index);
    assign cnt_ext  = IW'(r_count);

    // memory port control: the shift reads one ahead of the pointer
    always_comb begin
        mem_rd_addr = (r_state == S_SHIFT_RD) ? ptr_inc[PW-1:0] : r_ptr[PW-1:0];
        mem_we      = 1'b0;
        mem_wr_addr = r_count[PW-1:0];
        mem_wr_data = r_value;
        if (r_state == S_SHIFT_WR) begin
            mem_we      = 1'b1;
            mem_wr_addr = r_ptr[PW-1:0];
            mem_wr_data = r_rd_data;
        end else if (r_state == S_FETCH && scan_end &&
                     r_mode == sst_pkg::MODE_INSERT && !set_full) begin
            // append at the old count
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        r_rd_data <= r_mem[mem_rd_addr];
    end

    // sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode  <= sst_pkg::t_mode'(i_mode);
                        r_value <= i_value;
                        if (sst_pkg::t_mode'(i_mode) == sst_pkg::MODE_READ) begin
                            if (idx_ext < cnt_ext) begin
                                r_ptr   <= CW'(idx_ext);
                                r_state <= S_READ_RD;
                            end else begin
                                // bad index answers at once
                                r_valid      <= 1'b1;
                                r_status     <= sst_pkg::ST_NOTFOUND;
                                r_found      <= 1'b0;
                                r_pos        <= '0;
                                r_out_count  <= r_count;
                                r_read_value <= '0;
                            end
                        end else begin
                            r_ptr   <= '0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    if (scan_end) begin
                        // value absent
                        r_valid      <= 1'b1;
                        r_found      <= 1'b0;
                        r_pos        <= r_count;
                        r_read_value <= '0;
                        r_state      <= S_IDLE;
                        if (r_mode == sst_pkg::MODE_INSERT) begin
                            if (set_full) begin
                                r_status    <= sst_pkg::ST_FULL;
                                r_out_count <= r_count;
                            end else begin
                                r_status    <= sst_pkg::ST_OK;
                                r_count     <= ptr_inc[CW-1:0];
                                r_out_count <= ptr_inc[CW-1:0];
                            end
                        end else begin
                            r_status    <= sst_pkg::ST_NOTFOUND;
                            r_out_count <= r_count;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (hit) begin
                        r_found      <= 1'b1;
                        r_pos        <= r_ptr;
                        r_read_value <= '0;
                        if (r_mode == sst_pkg::MODE_DELETE) begin
                            r_state <= S_SHIFT_RD;
                        end else begin
                            r_valid     <= 1'b1;
                            r_out_count <= r_count;
                            r_status    <= (r_mode == sst_pkg::MODE_INSERT) ?
                                           sst_pkg::ST_PRESENT : sst_pkg::ST_OK;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_ptr   <= ptr_inc[CW-1:0];
                        r_state <= S_FETCH;
                    end
                end
                S_SHIFT_RD: begin
                    if (ptr_inc >= {1'b0, r_count}) begin
                        // last entry reached, drop the tail
                        r_count     <= r_count - 1'b1;
                        r_out_count <= r_count - 1'b1;
                        r_status    <= sst_pkg::ST_OK;
                        r_valid     <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_ptr   <= ptr_inc[CW-1:0];
                    r_state <= S_SHIFT_RD;
                end
                S_READ_RD: begin
                    r_state <= S_READ_OUT;
                end
                S_READ_OUT: begin
                    r_valid      <= 1'b1;
                    r_status     <= sst_pkg::ST_OK;
                    r_found      <= 1'b0;
                    r_pos        <= '0;
                    r_out_count  <= r_count;
                    r_read_value <= r_rd_data;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_position   = sst_pkg::OUT_POSW'(r_pos);
    assign o_count      = sst_pkg::OUT_POSW'(r_out_count);
    assign o_read_value = r_read_value;

endmodule

>>> src/sst_checker.sv
// port-level checks for the small set table, bound into every small_set_table instance
module sst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_status,
    input logic       o_found
);

    // a result beat only shows once the request has finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

    // an accepted request either answers at once or holds busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("request accepted but neither busy nor answered");

    // already present implies found, refusals imply not found
    a_status_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == sst_pkg::ST_PRESENT) |-> o_found)
        else $error("present status without found");

    a_full_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == sst_pkg::ST_FULL ||
                     o_status == sst_pkg::ST_NOTFOUND)) |-> !o_found)
        else $error("refusal status with found set");

endmodule

bind small_set_table sst_checker u_sst_checker (.*);

>>> tb/sv/set_table_checker.sv
`timescale 1ns / 1ps
// result checker for the small set table: tracks the set and compares every beat
module set_table_checker #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_index,
    input  logic               i_valid,
    input  logic [1:0]         i_status,
    input  logic               i_found,
    input  logic [5:0]         i_position,
    input  logic [5:0]         i_count,
    input  logic signed [31:0] i_read_value,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        sst_pkg::t_status   status;
        logic               found;
        logic [5:0]         position;
        logic [5:0]         count;
        logic signed [31:0] read_value;
    } t_set_result;

    logic signed [31:0] set_entries [CAPACITY];
    int                 set_size;
    t_set_result        expected_results [$];
    int                 fail_total;

    assign o_fail_count = fail_total;

    // applies one request to the tracked set and returns what the block must answer
    function automatic t_set_result apply_request(input sst_pkg::t_mode mode,
                                                  input logic signed [31:0] value,
                                                  input logic [4:0] idx);
        t_set_result res;
        int          hit;
        int          i;
        res.status     = sst_pkg::ST_OK;
        res.found      = 1'b0;
        res.position   = '0;
        res.read_value = '0;
        if (mode == sst_pkg::MODE_READ) begin
            if (int'(idx) < set_size)
                res.read_value = set_entries[idx];
            else
                res.status = sst_pkg::ST_NOTFOUND;
        end else begin
            hit = set_size;
            for (i = 0; i < set_size && hit == set_size; i++)
                if (set_entries[i] == value)
                    hit = i;
            res.found    = (hit != set_size);
            res.position = 6'(hit);
            case (mode)
                sst_pkg::MODE_LOOKUP: begin
                    res.status = res.found ? sst_pkg::ST_OK : sst_pkg::ST_NOTFOUND;
                end
                sst_pkg::MODE_INSERT: begin
                    if (res.found) begin
                        res.status = sst_pkg::ST_PRESENT;
                    end else if (set_size >= CAPACITY) begin
                        res.status = sst_pkg::ST_FULL;
                    end else begin
                        set_entries[set_size] = value;
                        set_size++;
                    end
                end
                default: begin
                    if (!res.found) begin
                        res.status = sst_pkg::ST_NOTFOUND;
                    end else begin
                        for (i = hit; i + 1 < set_size; i++)
                            set_entries[i] = set_entries[i + 1];
                        set_size--;
                    end
                end
            endcase
        end
        res.count = 6'(set_size);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_set_result want;
        if (!i_rst_n) begin
            set_size = 0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, i_status);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("found", 32'(want.found), 32'(i_found));
                    check_field("position", 32'(want.position), 32'(i_position));
                    check_field("count", 32'(want.count), 32'(i_count));
                    check_field("read_value", want.read_value, i_read_value);
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(
                    apply_request(sst_pkg::t_mode'(i_mode), i_value, i_index));
        end
        o_pending <= expected_results.size();
    end

endmodule

>>> tb/sv/tb_small_set_table.sv
`timescale 1ns / 1ps
// testbench top for the small set table: request stimulus and final verdict
module tb_small_set_table;

    localparam int CAPACITY     = 32;
    localparam int POOL_SIZE    = 40;
    localparam int RANDOM_ITEMS = 1450;
    // settle well beyond the slowest request
    localparam int SETTLE_CYCLES = 4 * CAPACITY + 16;

    // request mixes used for the random rounds
    typedef enum {
        FILL_HEAVY,
        DRAIN_HEAVY,
        EVEN_MIX
    } t_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_mode;
    logic signed [31:0] i_value;
    logic [4:0]         i_index;
    logic               o_valid;
    logic [1:0]         o_status;
    logic               o_found;
    logic [5:0]         o_position;
    logic [5:0]         o_count;
    logic signed [31:0] o_read_value;
    int                 fail_count;
    int                 pending;

    // values are drawn mostly from a pool a bit larger than the set, so that
    // lookups and deletes hit often and fill rounds can reach a full set
    logic signed [31:0] value_pool [POOL_SIZE];

    small_set_table #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_count      (o_count),
        .o_read_value (o_read_value)
    );

    set_table_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_index      (i_index),
        .i_valid      (o_valid),
        .i_status     (o_status),
        .i_found      (o_found),
        .i_position   (o_position),
        .i_count      (o_count),
        .i_read_value (o_read_value),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // idle length before a beat: mostly back to back or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // pool hit most of the time, a fully random word otherwise
    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 99) < 85)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            return $urandom;
    endfunction

    function automatic sst_pkg::t_mode pick_mode(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            FILL_HEAVY: begin
                if (r < 65)      return sst_pkg::MODE_INSERT;
                else if (r < 78) return sst_pkg::MODE_LOOKUP;
                else if (r < 90) return sst_pkg::MODE_READ;
                else             return sst_pkg::MODE_DELETE;
            end
            DRAIN_HEAVY: begin
                if (r < 55)      return sst_pkg::MODE_DELETE;
                else if (r < 70) return sst_pkg::MODE_LOOKUP;
                else if (r < 85) return sst_pkg::MODE_READ;
                else             return sst_pkg::MODE_INSERT;
            end
            default: begin
                if (r < 30)      return sst_pkg::MODE_INSERT;
                else if (r < 55) return sst_pkg::MODE_DELETE;
                else if (r < 80) return sst_pkg::MODE_LOOKUP;
                else             return sst_pkg::MODE_READ;
            end
        endcase
    endfunction

    // one request beat: optional idle stretch, then hold start until accepted
    task automatic send_request(input sst_pkg::t_mode mode,
                                input logic signed [31:0] value,
                                input logic [4:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            // start drops here and the fields carry junk while idle
            @(negedge i_clk);
            start   <= 1'b0;
            i_mode  <= 2'($urandom);
            i_value <= $urandom;
            i_index <= 5'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        i_index <= idx;
        // busy is registered, so its level at the falling edge holds to the next rising edge
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // stop sending and wait until every issued request has been answered
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int   sent;
        int   round_no;
        int   round_len;
        t_mix mix;

        start   = 1'b0;
        i_rst_n = 1'b0;
        i_mode  = sst_pkg::MODE_LOOKUP;
        i_value = '0;
        i_index = '0;

        // pool: the extremes of the value range first, then random words
        value_pool[0] = 32'sh0000_0000;
        value_pool[1] = -32'sd1;
        value_pool[2] = 32'sh7FFF_FFFF;
        value_pool[3] = 32'sh8000_0000;
        value_pool[4] = 32'sh0000_0001;
        for (int k = 5; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set behavior
        send_request(sst_pkg::MODE_LOOKUP, 32'sd5, 5'd0);    // lookup of an absent value
        send_request(sst_pkg::MODE_READ, 32'sd0, 5'd0);      // read of an empty set
        send_request(sst_pkg::MODE_DELETE, 32'sd5, 5'd0);    // delete of an absent value
        // fill with the extremes
        send_request(sst_pkg::MODE_INSERT, 32'sh8000_0000, 5'd0);
        send_request(sst_pkg::MODE_INSERT, 32'sh7FFF_FFFF, 5'd0);
        send_request(sst_pkg::MODE_INSERT, 32'sh0000_0000, 5'd0);
        send_request(sst_pkg::MODE_INSERT, -32'sd1, 5'd0);
        send_request(sst_pkg::MODE_INSERT, 32'sh0000_0000, 5'd31); // insert of a present value
        send_request(sst_pkg::MODE_LOOKUP, 32'sh7FFF_FFFF, 5'd0);
        send_request(sst_pkg::MODE_READ, 32'sd0, 5'd3);      // last valid index
        send_request(sst_pkg::MODE_READ, 32'sd0, 5'd4);      // index equal to the count
        send_request(sst_pkg::MODE_READ, 32'sd0, 5'd31);     // top index, out of range
        // deletes in the middle, at the front and at the back
        send_request(sst_pkg::MODE_DELETE, 32'sh7FFF_FFFF, 5'd0);
        send_request(sst_pkg::MODE_LOOKUP, -32'sd1, 5'd0);
        send_request(sst_pkg::MODE_DELETE, 32'sh8000_0000, 5'd0);
        send_request(sst_pkg::MODE_DELETE, -32'sd1, 5'd0);
        send_request(sst_pkg::MODE_READ, 32'sd0, 5'd0);
        send_request(sst_pkg::MODE_DELETE, 32'sh0000_0000, 5'd0); // back to empty
        send_request(sst_pkg::MODE_LOOKUP, 32'sh0000_0000, 5'd0);

        // random rounds: fill, drain and even mixes in turn, so the set size
        // swings between empty and full and inserts into a full set happen
        sent     = 0;
        round_no = 0;
        while (sent < RANDOM_ITEMS) begin
            case (round_no % 3)
                0:       mix = FILL_HEAVY;
                1:       mix = DRAIN_HEAVY;
                default: mix = EVEN_MIX;
            endcase
            // every eighth round starts from a fully drained pipeline
            if (round_no % 8 == 0)
                wait_drained();
            round_len = (mix == FILL_HEAVY) ? $urandom_range(30, 70) : $urandom_range(20, 60);
            repeat (round_len) begin
                send_request(pick_mode(mix), pick_value(), 5'($urandom_range(0, 31)));
                sent++;
            end
            round_no++;
        end

        // drain, then idle long enough to catch any stray result beat
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> small_set_table.f
src/sst_pkg.sv
src/small_set_table.sv
src/sst_checker.sv
tb/sv/set_table_checker.sv
tb/sv/tb_small_set_table.sv
